// ----- src/pac_pkg.sv -----
// Shared types, widths and codes for the polygon area and centroid block.
package pac_pkg;

    // Widths fixed by the word fields
    localparam int CW      = 16;          // coordinate field
    localparam int AREA_W  = 40;          // area result
    localparam int MODE_W  = 2;           // dimension mode register
    localparam int STAT_W  = 2;           // status result
    localparam int DIFF_W  = CW + 1;      // coordinate difference
    localparam int SUM3_W  = CW + 2;      // sum of three coordinates
    localparam int ST_W    = 2 * DIFF_W + 1;  // doubled triangle area
    localparam int PROD_W  = SUM3_W + ST_W;   // multiplier product
    localparam int TA_W    = 48;          // doubled area accumulator
    localparam int SA_W    = 64;          // moment accumulators
    localparam int DEN_W   = TA_W + 2;    // 3 * |doubled area|
    localparam int NUM_W   = SA_W + 2;    // 2 * |moment| + 3 * |doubled area|

    localparam longint AREA_MAX = 64'sd549755813887;
    localparam longint AREA_MIN = -64'sd549755813888;

    localparam logic [MODE_W-1:0] MODE_SEG   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_DEGEN = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_OVF   = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MUL1,
        OP_MUL2,
        OP_ST,
        OP_MOMX,
        OP_MOMY,
        OP_ACCY,
        OP_TABS,
        OP_DEN,
        OP_NABS,
        OP_DINIT,
        OP_DSTEP,
        OP_DDONE,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_y;    // division works on the y moment
    } t_cmd;

    typedef struct packed {
        logic fan_step;  // accepting now starts a triangle update
        logic last;      // word just taken closed the cell
        logic need_div;  // polygon result needs the centroid divisions
    } t_sts;

endpackage

// ----- src/polygon_area_centroid.sv -----
// Top level: signed area and centroid of one mesh cell from a vertex stream.
//
// Input channel (i_in_valid / o_in_ready) carries one vertex word per transfer:
// signed Q8.8 coordinates, with i_last_vertex set on the closing vertex of a cell.
// Output channel (o_out_valid / i_out_ready) carries one result word per cell:
// Q24.16 area (or segment length), Q8.8 centroid and a status code.
// i_cfg_we / i_cfg_wdata write the dimension mode: 1 for segment, else polygon.
// One vertex is in work at a time. From the third polygon vertex on, accepting
// a vertex also starts a triangle update on the shared multiplier. After the
// last vertex, a polygon cell needing a centroid runs the bit-serial divider
// once for x and once for y before its result word is loaded.
// The output register holds a finished word while the next cell streams in;
// if it is still occupied when the next result is ready, the block waits there.
// Synchronous reset empties the output, clears the cell and sets polygon mode.
module polygon_area_centroid #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pac_pkg::MODE_W-1:0]        i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [pac_pkg::CW-1:0]     i_coord_x,
    input  logic signed [pac_pkg::CW-1:0]     i_coord_y,
    input  logic                              i_last_vertex,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [pac_pkg::AREA_W-1:0] o_area,
    output logic signed [pac_pkg::CW-1:0]     o_centroid_x,
    output logic signed [pac_pkg::CW-1:0]     o_centroid_y,
    output logic [pac_pkg::STAT_W-1:0]        o_status
);

    pac_pkg::t_cmd cmd;
    pac_pkg::t_sts sts;

    pac_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pac_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_last_vertex (i_last_vertex),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_area        (o_area),
        .o_centroid_x  (o_centroid_x),
        .o_centroid_y  (o_centroid_y),
        .o_status      (o_status)
    );

endmodule

// ----- src/pac_ctrl.sv -----
// Sequencer for the polygon area and centroid block.
module pac_ctrl #(
    parameter int COORD_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output pac_pkg::t_cmd o_cmd,
    input  pac_pkg::t_sts i_sts
);

    localparam int STEP_W = $clog2(COORD_BITS + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COORD_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_FIN,
        S_DEN,
        S_NABS,
        S_DINIT,
        S_DSTEP,
        S_DDONE,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic                r_sel_y, n_sel_y;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid;
    logic                slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_sel_y      = r_sel_y;
        n_step       = r_step;
        o_cmd.op     = pac_pkg::OP_NONE;
        o_cmd.sel_y  = r_sel_y;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = pac_pkg::OP_ACCEPT;
                    n_state  = i_sts.fan_step ? S_M1 : S_CHK;
                end
            end
            S_CHK: begin
                n_state = i_sts.last ? S_FIN : S_IDLE;
            end
            S_M1: begin
                o_cmd.op = pac_pkg::OP_MUL1;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = pac_pkg::OP_MUL2;
                n_state  = S_M3;
            end
            S_M3: begin
                o_cmd.op = pac_pkg::OP_ST;
                n_state  = S_M4;
            end
            S_M4: begin
                o_cmd.op = pac_pkg::OP_MOMX;
                n_state  = S_M5;
            end
            S_M5: begin
                o_cmd.op = pac_pkg::OP_MOMY;
                n_state  = S_M6;
            end
            S_M6: begin
                o_cmd.op = pac_pkg::OP_ACCY;
                n_state  = i_sts.last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                o_cmd.op = pac_pkg::OP_TABS;
                n_state  = i_sts.need_div ? S_DEN : S_OUT;
            end
            S_DEN: begin
                o_cmd.op = pac_pkg::OP_DEN;
                n_sel_y  = 1'b0;
                n_state  = S_NABS;
            end
            S_NABS: begin
                o_cmd.op = pac_pkg::OP_NABS;
                n_state  = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.op = pac_pkg::OP_DINIT;
                n_step   = '0;
                n_state  = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.op = pac_pkg::OP_DSTEP;
                n_step   = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_DDONE;
                end
            end
            S_DDONE: begin
                o_cmd.op = pac_pkg::OP_DDONE;
                if (!r_sel_y) begin
                    n_sel_y = 1'b1;
                    n_state = S_NABS;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.op = pac_pkg::OP_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel_y     <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel_y <= n_sel_y;
            r_step  <= n_step;
            if (o_cmd.op == pac_pkg::OP_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a word is still in work");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == pac_pkg::OP_LOAD) |=> r_out_valid)
        else $error("result loaded but not offered");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSTEP) |-> (r_step <= STEP_LAST))
        else $error("division step count overran");
`endif

endmodule

// ----- src/pac_dp.sv -----
// Datapath: vertex registers, shared multiplier, accumulators, divider, result word.
module pac_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pac_pkg::MODE_W-1:0]        i_cfg_wdata,
    input  logic signed [pac_pkg::CW-1:0]     i_coord_x,
    input  logic signed [pac_pkg::CW-1:0]     i_coord_y,
    input  logic                              i_last_vertex,
    input  pac_pkg::t_cmd                     i_cmd,
    output pac_pkg::t_sts                     o_sts,
    output logic signed [pac_pkg::AREA_W-1:0] o_area,
    output logic signed [pac_pkg::CW-1:0]     o_centroid_x,
    output logic signed [pac_pkg::CW-1:0]     o_centroid_y,
    output logic [pac_pkg::STAT_W-1:0]        o_status
);

    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int DEN2_W = pac_pkg::DEN_W + 1 + COORD_BITS;
    localparam int DIV_W  = (pac_pkg::NUM_W > DEN2_W) ? pac_pkg::NUM_W : DEN2_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
    localparam logic [COORD_BITS:0] QHALF = (COORD_BITS + 1)'(1) << (COORD_BITS - 1);

    // cell state
    logic [pac_pkg::MODE_W-1:0]        r_mode;
    logic [CNT_W-1:0]                  r_count;
    logic                              r_ovf;
    logic signed [pac_pkg::CW-1:0]     r_fx, r_fy, r_px, r_py;
    logic signed [pac_pkg::TA_W-1:0]   r_ta;
    logic signed [pac_pkg::SA_W-1:0]   r_sx, r_sy;

    // work registers
    logic signed [pac_pkg::CW-1:0]     r_vx, r_vy;
    logic                              r_last, r_seg;
    logic signed [pac_pkg::PROD_W-1:0] r_prod;
    logic signed [pac_pkg::ST_W-1:0]   r_p1, r_st;
    logic [pac_pkg::TA_W-1:0]          r_tabs;
    logic [pac_pkg::DEN_W-1:0]         r_dmag;
    logic [pac_pkg::SA_W-1:0]          r_nabs;
    logic                              r_nneg, r_neg;
    logic [DIV_W-1:0]                  r_rem, r_dv;
    logic [COORD_BITS:0]               r_q;
    logic signed [pac_pkg::CW-1:0]     r_cx_res, r_cy_res;

    logic signed [COORD_BITS-1:0]      x_low, y_low;
    logic signed [pac_pkg::CW-1:0]     x_in, y_in;
    logic                              seg_now;
    logic signed [pac_pkg::SUM3_W-1:0] mul_a;
    logic signed [pac_pkg::ST_W-1:0]   mul_b;
    logic signed [pac_pkg::PROD_W-1:0] mul_p;
    logic signed [pac_pkg::DIFF_W-1:0] dxp, dyp, dxc, dyc;
    logic signed [pac_pkg::SUM3_W-1:0] sx3, sy3;
    logic signed [pac_pkg::SA_W-1:0]   num;
    logic                              ge;
    logic                              q_sat;
    logic [COORD_BITS:0]               q_mag;
    logic signed [COORD_BITS:0]        q_res;
    logic signed [pac_pkg::TA_W-1:0]   ta_adj, ta_half, ta_clamp;
    logic signed [pac_pkg::DIFF_W-1:0] seg_d, seg_sum;
    logic [pac_pkg::DIFF_W-1:0]        seg_abs;
    logic                              ta_zero;
    logic [pac_pkg::AREA_W-1:0]        res_area;
    logic signed [pac_pkg::CW-1:0]     res_cx, res_cy;
    logic [pac_pkg::STAT_W-1:0]        res_status;

    assign x_low   = i_coord_x[COORD_BITS-1:0];
    assign y_low   = i_coord_y[COORD_BITS-1:0];
    assign x_in    = pac_pkg::CW'(x_low);
    assign y_in    = pac_pkg::CW'(y_low);
    assign seg_now = (r_mode == pac_pkg::MODE_SEG);
    assign ta_zero = (r_ta == '0);

    assign o_sts.fan_step = (r_count >= CNT_TWO) && (r_count < CNT_MAX) && !seg_now;
    assign o_sts.last     = r_last;
    assign o_sts.need_div = !r_ovf && !r_seg && (r_count >= CNT_THREE) && !ta_zero;

    // triangle fan terms: differences relative to the first vertex, and three-vertex sums
    assign dxp = pac_pkg::DIFF_W'(r_px) - pac_pkg::DIFF_W'(r_fx);
    assign dyp = pac_pkg::DIFF_W'(r_py) - pac_pkg::DIFF_W'(r_fy);
    assign dxc = pac_pkg::DIFF_W'(r_vx) - pac_pkg::DIFF_W'(r_fx);
    assign dyc = pac_pkg::DIFF_W'(r_vy) - pac_pkg::DIFF_W'(r_fy);
    assign sx3 = pac_pkg::SUM3_W'(r_fx) + pac_pkg::SUM3_W'(r_px) + pac_pkg::SUM3_W'(r_vx);
    assign sy3 = pac_pkg::SUM3_W'(r_fy) + pac_pkg::SUM3_W'(r_py) + pac_pkg::SUM3_W'(r_vy);

    // one shared multiplier
    always_comb begin
        mul_a = pac_pkg::SUM3_W'(dxp);
        mul_b = pac_pkg::ST_W'(dyc);
        case (i_cmd.op)
            pac_pkg::OP_MUL2: begin
                mul_a = pac_pkg::SUM3_W'(dxc);
                mul_b = pac_pkg::ST_W'(dyp);
            end
            pac_pkg::OP_MOMX: begin
                mul_a = sx3;
                mul_b = r_st;
            end
            pac_pkg::OP_MOMY: begin
                mul_a = sy3;
                mul_b = r_st;
            end
            default: ;
        endcase
    end
    assign mul_p = pac_pkg::PROD_W'(mul_a) * pac_pkg::PROD_W'(mul_b);

    assign num = i_cmd.sel_y ? r_sy : r_sx;
    assign ge  = (r_rem >= r_dv);

    // quotient saturates once it reaches half range: to max if positive, to min if negative
    assign q_sat = (r_q >= QHALF);
    assign q_mag = q_sat ? QHALF : r_q;
    assign q_res = r_neg ? -$signed(q_mag) : (q_sat ? $signed(QHALF - 1'b1) : $signed(q_mag));

    // area: doubled sum halved toward zero, then clamped
    assign ta_adj  = r_ta + $signed({{(pac_pkg::TA_W-1){1'b0}}, r_ta[pac_pkg::TA_W-1]});
    assign ta_half = ta_adj >>> 1;
    always_comb begin
        ta_clamp = ta_half;
        if (ta_half > pac_pkg::AREA_MAX) begin
            ta_clamp = pac_pkg::TA_W'(pac_pkg::AREA_MAX);
        end else if (ta_half < pac_pkg::AREA_MIN) begin
            ta_clamp = pac_pkg::TA_W'(pac_pkg::AREA_MIN);
        end
    end

    assign seg_d   = pac_pkg::DIFF_W'(r_px) - pac_pkg::DIFF_W'(r_fx);
    assign seg_abs = seg_d[pac_pkg::DIFF_W-1] ? pac_pkg::DIFF_W'(-seg_d) : pac_pkg::DIFF_W'(seg_d);
    assign seg_sum = pac_pkg::DIFF_W'(r_px) + pac_pkg::DIFF_W'(r_fx);

    always_comb begin
        res_area   = '0;
        res_cx     = '0;
        res_cy     = '0;
        res_status = pac_pkg::STATUS_OK;
        if (r_ovf) begin
            res_status = pac_pkg::STATUS_OVF;
        end else if (r_seg) begin
            if (r_count < CNT_TWO) begin
                res_status = pac_pkg::STATUS_DEGEN;
            end else begin
                res_area = pac_pkg::AREA_W'({seg_abs, 8'b0});
                if (seg_abs == '0) begin
                    res_status = pac_pkg::STATUS_DEGEN;
                end else begin
                    res_cx = pac_pkg::CW'(seg_sum >>> 1);
                end
            end
        end else begin
            res_area = ta_clamp[pac_pkg::AREA_W-1:0];
            if ((r_count < CNT_THREE) || ta_zero) begin
                res_status = pac_pkg::STATUS_DEGEN;
            end else begin
                res_cx = r_cx_res;
                res_cy = r_cy_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pac_pkg::MODE_RESET;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_fx    <= '0;
            r_fy    <= '0;
            r_px    <= '0;
            r_py    <= '0;
            r_ta    <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            unique case (i_cmd.op)
                pac_pkg::OP_ACCEPT: begin
                    if (r_count >= CNT_MAX) begin
                        r_ovf <= 1'b1;   // word dropped
                    end else begin
                        r_count <= r_count + 1'b1;
                        if (r_count == '0) begin
                            r_fx <= x_in;
                            r_fy <= y_in;
                        end else if (r_count == CNT_W'(1)) begin
                            r_px <= x_in;
                            r_py <= y_in;
                        end
                    end
                end
                pac_pkg::OP_MOMX: r_ta <= r_ta + pac_pkg::TA_W'(r_st);
                pac_pkg::OP_MOMY: r_sx <= r_sx + pac_pkg::SA_W'(r_prod);
                pac_pkg::OP_ACCY: begin
                    r_sy <= r_sy + pac_pkg::SA_W'(r_prod);
                    r_px <= r_vx;
                    r_py <= r_vy;
                end
                pac_pkg::OP_LOAD: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_fx    <= '0;
                    r_fy    <= '0;
                    r_px    <= '0;
                    r_py    <= '0;
                    r_ta    <= '0;
                    r_sx    <= '0;
                    r_sy    <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            pac_pkg::OP_ACCEPT: begin
                r_vx   <= x_in;
                r_vy   <= y_in;
                r_last <= i_last_vertex;
                r_seg  <= seg_now;
            end
            pac_pkg::OP_MUL1: r_prod <= mul_p;
            pac_pkg::OP_MUL2: begin
                r_p1   <= pac_pkg::ST_W'(r_prod);
                r_prod <= mul_p;
            end
            pac_pkg::OP_ST:   r_st   <= r_p1 - pac_pkg::ST_W'(r_prod);
            pac_pkg::OP_MOMX: r_prod <= mul_p;
            pac_pkg::OP_MOMY: r_prod <= mul_p;
            pac_pkg::OP_TABS: begin
                r_tabs <= r_ta[pac_pkg::TA_W-1] ? pac_pkg::TA_W'(-r_ta) : pac_pkg::TA_W'(r_ta);
            end
            pac_pkg::OP_DEN: begin
                r_dmag <= pac_pkg::DEN_W'(r_tabs) + (pac_pkg::DEN_W'(r_tabs) << 1);
            end
            pac_pkg::OP_NABS: begin
                r_nneg <= num[pac_pkg::SA_W-1];
                r_nabs <= num[pac_pkg::SA_W-1] ? pac_pkg::SA_W'(-num) : pac_pkg::SA_W'(num);
            end
            pac_pkg::OP_DINIT: begin
                // round half away: (2|n| + |d|) / (2|d|), d = 3 * doubled area
                r_rem <= (DIV_W'(r_nabs) << 1) + DIV_W'(r_dmag);
                r_dv  <= DIV_W'(r_dmag) << (COORD_BITS + 1);
                r_q   <= '0;
                r_neg <= r_nneg ^ r_ta[pac_pkg::TA_W-1];
            end
            pac_pkg::OP_DSTEP: begin
                if (ge) begin
                    r_rem <= r_rem - r_dv;
                end
                r_q  <= {r_q[COORD_BITS-1:0], ge};
                r_dv <= r_dv >> 1;
            end
            pac_pkg::OP_DDONE: begin
                if (i_cmd.sel_y) begin
                    r_cy_res <= pac_pkg::CW'(q_res);
                end else begin
                    r_cx_res <= pac_pkg::CW'(q_res);
                end
            end
            pac_pkg::OP_LOAD: begin
                o_area       <= res_area;
                o_centroid_x <= res_cx;
                o_centroid_y <= res_cy;
                o_status     <= res_status;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("vertex count beyond the cell limit");

    a_cell_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == pac_pkg::OP_LOAD) |=> (r_count == '0 && !r_ovf && r_ta == '0))
        else $error("cell state not cleared after a result");
`endif

endmodule
